// File: src/svc_pkg.sv
// Shared widths, constants and codes for the seismic velocity converter.
package svc_pkg;

    localparam int AXIS_W        = 24;
    localparam int VEL_W         = 20;
    localparam int PROD_W        = 64;
    localparam int MUL_A_W       = 40;
    localparam int MUL_B_W       = 24;
    localparam int DEN_W         = 24;
    localparam int ROOT_W        = 33;
    localparam int KIND_W        = 2;
    localparam int CFG_IDX_W     = 2;
    localparam int STAT_W        = 2;
    localparam int MAX_PAIRS_DEF = 256;

    typedef logic [AXIS_W-1:0] t_axis;
    typedef logic [VEL_W-1:0]  t_vel;
    typedef logic [PROD_W-1:0] t_prod;

    localparam t_axis AXIS_MAX = '1;
    localparam t_vel  VEL_MAX  = '1;

    // time/depth scale factors (ms two-way time, Q-formats cancel)
    localparam logic [DEN_W-1:0] K_FIRST = DEN_W'(32000);
    localparam logic [DEN_W-1:0] K_STEP  = DEN_W'(64000);

    // velocity kinds
    localparam logic [KIND_W-1:0] VK_RMS = 2'd0;
    localparam logic [KIND_W-1:0] VK_AVG = 2'd1;
    localparam logic [KIND_W-1:0] VK_INT = 2'd2;
    localparam logic [KIND_W-1:0] VK_ALT = 2'd3;

    // axis kinds
    localparam logic AX_TIME  = 1'b0;
    localparam logic AX_DEPTH = 1'b1;

    // commands
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_TABLE = 2'd1;
    localparam logic [STAT_W-1:0] ST_SAT      = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IN_VK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IN_AX  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_VK = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_AX = 2'd3;

endpackage

// File: src/svc_mul.sv
// Shift-add multiplier, one multiplier bit per cycle.
module svc_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [svc_pkg::MUL_A_W-1:0] i_a,
    input  logic [svc_pkg::MUL_B_W-1:0] i_b,
    output logic                        o_done,
    output svc_pkg::t_prod              o_prod
);
    import svc_pkg::*;

    localparam int CNT_W = $clog2(MUL_B_W);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    t_prod              r_acc;
    t_prod              r_mcand;
    logic [MUL_B_W-1:0] r_mplier;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MUL_B_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc    <= '0;
            r_mcand  <= PROD_W'(i_a);
            r_mplier <= i_b;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= r_mcand << 1;
            r_mplier <= r_mplier >> 1;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// File: src/svc_div.sv
// Restoring divider, one quotient bit per cycle, rounds half up at the end.
module svc_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  svc_pkg::t_prod            i_num,
    input  logic [svc_pkg::DEN_W-1:0] i_den,
    output logic                      o_done,
    output svc_pkg::t_prod            o_quo
);
    import svc_pkg::*;

    localparam int CNT_W = $clog2(PROD_W);

    logic             r_busy;
    logic             r_fin;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    t_prod            r_quo;

    logic [DEN_W:0]   rem2;
    logic             ge;
    logic [DEN_W:0]   rem_n;

    always_comb begin
        rem2  = {r_rem, r_quo[PROD_W-1]};
        ge    = (rem2 >= {1'b0, r_den});
        rem_n = ge ? (rem2 - {1'b0, r_den}) : rem2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(PROD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_quo <= i_num;
        end else if (r_busy) begin
            r_rem <= rem_n[DEN_W-1:0];
            r_quo <= {r_quo[PROD_W-2:0], ge};
        end else if (r_fin) begin
            // round to nearest: 2*rem >= den
            if ({r_rem, 1'b0} >= {1'b0, r_den}) begin
                r_quo <= r_quo + 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// File: src/svc_sqrt.sv
// Bit-pair integer square root, two radicand bits per cycle, rounded to nearest.
module svc_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  svc_pkg::t_prod             i_rad,
    output logic                       o_done,
    output logic [svc_pkg::ROOT_W-1:0] o_root
);
    import svc_pkg::*;

    localparam int REM_W = ROOT_W + 2;
    localparam int CNT_W = $clog2(PROD_W / 2);

    logic              r_busy;
    logic              r_fin;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    t_prod             r_src;

    logic [REM_W-1:0]  rem4;
    logic [REM_W-1:0]  trial;
    logic              ge;

    always_comb begin
        rem4  = {r_rem[REM_W-3:0], r_src[PROD_W-1 -: 2]};
        trial = {r_root, 2'b01};
        ge    = (rem4 >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(PROD_W / 2 - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_root <= '0;
            r_src  <= i_rad;
        end else if (r_busy) begin
            r_src <= r_src << 2;
            if (ge) begin
                r_rem  <= rem4 - trial;
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem4;
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end else if (r_fin) begin
            // remainder above root: nearer to the next integer
            if (r_rem > REM_W'(r_root)) begin
                r_root <= r_root + 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// File: src/seismic_velocity_converter_unit.sv
// Top level: table memories, conversion and query sequencer, shared arithmetic units.
//
//  channel   | handshake           | payload
//  ----------+---------------------+------------------------------------------------
//  item in   | start, busy         | i_command, i_axis_value, i_velocity_in,
//            |                     | i_last_pair
//  result    | o_valid (1 cycle)   | o_velocity_out, o_status
//  config    | i_cfg_we            | i_cfg_idx, i_cfg_wdata
//
// A load item stores one pair while there is room; if it carries last_pair, a
// conversion pass walks the table once, one entry at a time, through the shared
// multiplier, divider and square root. A query ends on a hit at either end of the
// table; otherwise it runs a binary search over the memory read port, then two
// multiplies and one divide. Reset is synchronous, active low, and clears the
// control state only; the tables are not cleared and need no clearing pass. busy
// is high while a conversion pass or a query runs; a load without last_pair and a
// query with no table are handled in idle with busy low.
// The receiver cannot stall: each result shows for exactly one cycle.
module seismic_velocity_converter_unit #(
    parameter int MAX_PAIRS = svc_pkg::MAX_PAIRS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_command,
    input  svc_pkg::t_axis                i_axis_value,
    input  svc_pkg::t_vel                 i_velocity_in,
    input  logic                          i_last_pair,
    output logic                          o_valid,
    output svc_pkg::t_vel                 o_velocity_out,
    output logic [svc_pkg::STAT_W-1:0]    o_status,
    input  logic                          i_cfg_we,
    input  logic [svc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [svc_pkg::KIND_W-1:0]    i_cfg_wdata
);
    import svc_pkg::*;

    localparam int IW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam int CW = $clog2(MAX_PAIRS + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_CRD, S_CLD, S_HI_A, S_HI_B, S_DIX, S_DIX_D, S_DIX_S,
        S_AX, S_AX_M, S_AX_D, S_OUT, S_OUT_A, S_OUT_B, S_OUT_Q, S_OUT_D,
        S_OUT_S, S_WR, Q_A0, Q_A1, Q_AN, Q_BS, Q_BM, Q_RL, Q_RH, Q_M1,
        Q_M2, Q_DV
    } t_state;

    t_state r_state;

    // configuration
    logic [KIND_W-1:0] r_ivk, r_ovk;
    logic              r_iax, r_oax;

    // table bookkeeping
    logic [CW-1:0] r_count;
    logic          r_ready;
    t_axis         r_last;
    logic [IW-1:0] r_idx;

    // conversion datapath
    t_axis r_a, r_ap, r_tz, r_tzp;
    t_vel  r_vi, r_v1, r_v1p, r_v2;
    t_prod r_hi, r_hip, r_sum;
    logic  r_sat_i, r_sat_acc;

    // query datapath
    t_axis         r_x, r_t0, r_t1;
    t_vel          r_w0, r_w1;
    logic          r_sat1;
    logic [IW-1:0] r_lo, r_hi_i;

    // results
    logic  r_valid;
    t_vel  r_vel_out;
    logic [STAT_W-1:0] r_status;

    // tables
    t_axis r_axis_mem [MAX_PAIRS];
    t_vel  r_vel_mem  [MAX_PAIRS];
    t_axis r_tz_mem   [MAX_PAIRS];
    t_vel  r_v2_mem   [MAX_PAIRS];
    logic  r_sat_mem  [MAX_PAIRS];
    t_axis r_axis_rd, r_tz_rd;
    t_vel  r_vel_rd, r_v2_rd;
    logic  r_sat_rd;

    // shared unit ports
    logic                r_mul_start, r_div_start, r_sqrt_start;
    logic [MUL_A_W-1:0]  r_mul_a;
    logic [MUL_B_W-1:0]  r_mul_b;
    t_prod               r_div_num, r_sqrt_rad;
    logic [DEN_W-1:0]    r_div_den;
    logic                mul_done, div_done, sqrt_done;
    t_prod               mul_prod, div_quo;
    logic [ROOT_W-1:0]   sqrt_root;

    // derived values
    logic [KIND_W-1:0] ivk_e, ovk_e;
    logic              same_kinds, first;
    t_axis             d_a, dt;
    logic [VEL_W:0]    v1_sum;
    logic [CW-1:0]     cnt_eff, cnt_nxt;
    logic              room;
    t_axis             x_load;
    logic              load_we;
    logic [IW-1:0]     last_idx, mid, rd_addr;
    logic [IW:0]       span;
    logic              sat_acc_new;
    t_prod             tz_sum;
    logic [CW-1:0]     cnt_m1;

    always_comb begin
        ivk_e      = (r_ivk == VK_ALT) ? VK_INT : r_ivk;
        ovk_e      = (r_ovk == VK_ALT) ? VK_INT : r_ovk;
        same_kinds = (ivk_e == ovk_e) && (r_iax == r_oax);
        first      = (r_idx == '0);
        d_a        = r_a - r_ap;
        dt         = first ? r_tz : (r_tz - r_tzp);
        v1_sum     = {1'b0, r_v1} + {1'b0, r_v1p};
        // a load after a finished conversion starts a new table
        cnt_eff    = r_ready ? '0 : r_count;
        room       = (cnt_eff < CW'(MAX_PAIRS));
        cnt_nxt    = room ? (cnt_eff + 1'b1) : cnt_eff;
        x_load     = ((cnt_eff != '0) && (i_axis_value < r_last)) ? r_last : i_axis_value;
        load_we    = (r_state == S_IDLE) && start && (i_command == CMD_LOAD) && room;
        cnt_m1     = r_count - 1'b1;
        last_idx   = cnt_m1[IW-1:0];
        span       = {1'b0, r_hi_i} - {1'b0, r_lo};
        mid        = IW'(({1'b0, r_lo} + {1'b0, r_hi_i}) >> 1);
        sat_acc_new = r_sat_acc | (r_sat_i & ~same_kinds);
        tz_sum     = (first ? '0 : PROD_W'(r_tzp)) + div_quo;
    end

    always_comb begin
        unique case (r_state)
            S_CRD:   rd_addr = r_idx;
            Q_A0:    rd_addr = '0;
            Q_A1:    rd_addr = last_idx;
            Q_BS:    rd_addr = (span > (IW+1)'(1)) ? mid : r_lo;
            Q_RL:    rd_addr = r_lo + 1'b1;
            default: rd_addr = r_idx;
        endcase
    end

    // input pair tables: written by loads, read by the conversion pass
    always_ff @(posedge i_clk) begin
        if (load_we) begin
            r_axis_mem[cnt_eff[IW-1:0]] <= x_load;
            r_vel_mem[cnt_eff[IW-1:0]]  <= i_velocity_in;
        end
        r_axis_rd <= r_axis_mem[rd_addr];
        r_vel_rd  <= r_vel_mem[rd_addr];
    end

    // converted tables: written by the conversion pass, read by queries
    always_ff @(posedge i_clk) begin
        if (r_state == S_WR) begin
            r_tz_mem[r_idx]  <= same_kinds ? r_a : r_tz;
            r_v2_mem[r_idx]  <= same_kinds ? r_vi : r_v2;
            r_sat_mem[r_idx] <= sat_acc_new;
        end
        r_tz_rd  <= r_tz_mem[rd_addr];
        r_v2_rd  <= r_v2_mem[rd_addr];
        r_sat_rd <= r_sat_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ivk        <= VK_RMS;
            r_iax        <= AX_TIME;
            r_ovk        <= VK_RMS;
            r_oax        <= AX_TIME;
            r_count      <= '0;
            r_ready      <= 1'b0;
            r_valid      <= 1'b0;
            r_mul_start  <= 1'b0;
            r_div_start  <= 1'b0;
            r_sqrt_start <= 1'b0;
        end else begin
            r_valid      <= 1'b0;
            r_mul_start  <= 1'b0;
            r_div_start  <= 1'b0;
            r_sqrt_start <= 1'b0;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_IN_VK:  r_ivk <= i_cfg_wdata;
                    REG_IN_AX:  r_iax <= i_cfg_wdata[0];
                    REG_OUT_VK: r_ovk <= i_cfg_wdata;
                    REG_OUT_AX: r_oax <= i_cfg_wdata[0];
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        if (i_command == CMD_LOAD) begin
                            r_ready <= 1'b0;
                            r_count <= cnt_nxt;
                            if (room) begin
                                r_last <= x_load;
                            end
                            if (i_last_pair && (cnt_nxt != '0)) begin
                                r_idx     <= '0;
                                r_sat_acc <= 1'b0;
                                r_state   <= S_CRD;
                            end
                        end else begin
                            r_x <= i_axis_value;
                            if (!r_ready) begin
                                r_valid   <= 1'b1;
                                r_vel_out <= '0;
                                r_status  <= ST_NO_TABLE;
                            end else begin
                                r_state <= Q_A0;
                            end
                        end
                    end
                end

                // ---- conversion pass, one entry per round ----
                S_CRD: r_state <= S_CLD;

                S_CLD: begin
                    r_a     <= r_axis_rd;
                    r_vi    <= r_vel_rd;
                    r_sat_i <= 1'b0;
                    if (ivk_e == VK_INT) begin
                        r_state <= S_DIX;
                    end else begin
                        r_mul_start <= 1'b1;
                        r_mul_a     <= MUL_A_W'(r_vel_rd);
                        r_mul_b     <= (ivk_e == VK_RMS) ? MUL_B_W'(r_vel_rd) : r_axis_rd;
                        r_state     <= S_HI_A;
                    end
                end

                S_HI_A: begin
                    if (mul_done) begin
                        if (ivk_e == VK_RMS) begin
                            r_mul_start <= 1'b1;
                            r_mul_a     <= mul_prod[MUL_A_W-1:0];
                            r_mul_b     <= r_a;
                            r_state     <= S_HI_B;
                        end else begin
                            r_hi    <= mul_prod;
                            r_state <= S_DIX;
                        end
                    end
                end

                S_HI_B: begin
                    if (mul_done) begin
                        r_hi    <= mul_prod;
                        r_state <= S_DIX;
                    end
                end

                // Dix step; a non-positive step keeps the previous interval velocity
                S_DIX: begin
                    if ((ivk_e == VK_INT) || first) begin
                        r_v1    <= r_vi;
                        r_state <= S_AX;
                    end else if ((r_hi > r_hip) && (d_a != '0)) begin
                        r_div_start <= 1'b1;
                        r_div_num   <= r_hi - r_hip;
                        r_div_den   <= d_a;
                        r_state     <= S_DIX_D;
                    end else begin
                        r_v1    <= r_v1p;
                        r_state <= S_AX;
                    end
                end

                S_DIX_D: begin
                    if (div_done) begin
                        if (ivk_e == VK_RMS) begin
                            r_sqrt_start <= 1'b1;
                            r_sqrt_rad   <= div_quo;
                            r_state      <= S_DIX_S;
                        end else begin
                            if (div_quo > PROD_W'(VEL_MAX)) begin
                                r_v1    <= VEL_MAX;
                                r_sat_i <= 1'b1;
                            end else begin
                                r_v1 <= div_quo[VEL_W-1:0];
                            end
                            r_state <= S_AX;
                        end
                    end
                end

                S_DIX_S: begin
                    if (sqrt_done) begin
                        if (sqrt_root > ROOT_W'(VEL_MAX)) begin
                            r_v1    <= VEL_MAX;
                            r_sat_i <= 1'b1;
                        end else begin
                            r_v1 <= sqrt_root[VEL_W-1:0];
                        end
                        r_state <= S_AX;
                    end
                end

                // axis conversion between two-way time and depth
                S_AX: begin
                    if (r_iax == r_oax) begin
                        r_tz    <= r_a;
                        r_state <= S_OUT;
                    end else if (r_iax == AX_TIME) begin
                        r_mul_start <= 1'b1;
                        r_mul_a     <= first ? MUL_A_W'(r_v1) : MUL_A_W'(v1_sum);
                        r_mul_b     <= first ? r_a : d_a;
                        r_state     <= S_AX_M;
                    end else if (first) begin
                        if (r_a == '0) begin
                            r_tz    <= '0;
                            r_state <= S_OUT;
                        end else if (r_v1 == '0) begin
                            r_tz    <= AXIS_MAX;
                            r_sat_i <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_mul_start <= 1'b1;
                            r_mul_a     <= MUL_A_W'(K_FIRST);
                            r_mul_b     <= r_a;
                            r_state     <= S_AX_M;
                        end
                    end else begin
                        if (d_a == '0) begin
                            r_tz    <= r_tzp;
                            r_state <= S_OUT;
                        end else if (v1_sum == '0) begin
                            // zero velocity sum: step saturates
                            r_tz    <= AXIS_MAX;
                            r_sat_i <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_mul_start <= 1'b1;
                            r_mul_a     <= MUL_A_W'(K_STEP);
                            r_mul_b     <= d_a;
                            r_state     <= S_AX_M;
                        end
                    end
                end

                S_AX_M: begin
                    if (mul_done) begin
                        r_div_start <= 1'b1;
                        r_div_num   <= mul_prod;
                        if (r_iax == AX_TIME) begin
                            r_div_den <= first ? K_FIRST : K_STEP;
                        end else begin
                            r_div_den <= first ? DEN_W'(r_v1) : DEN_W'(v1_sum);
                        end
                        r_state <= S_AX_D;
                    end
                end

                S_AX_D: begin
                    if (div_done) begin
                        if (tz_sum > PROD_W'(AXIS_MAX)) begin
                            r_tz    <= AXIS_MAX;
                            r_sat_i <= 1'b1;
                        end else begin
                            r_tz <= tz_sum[AXIS_W-1:0];
                        end
                        r_state <= S_OUT;
                    end
                end

                // output velocity: interval kind passes through, others take a running sum over the converted axis
                S_OUT: begin
                    if (ovk_e == VK_INT) begin
                        r_v2    <= r_v1;
                        r_state <= S_WR;
                    end else begin
                        r_mul_start <= 1'b1;
                        r_mul_a     <= MUL_A_W'(r_v1);
                        r_mul_b     <= (ovk_e == VK_RMS) ? MUL_B_W'(r_v1) : dt;
                        r_state     <= S_OUT_A;
                    end
                end

                S_OUT_A: begin
                    if (mul_done) begin
                        if (ovk_e == VK_RMS) begin
                            r_mul_start <= 1'b1;
                            r_mul_a     <= mul_prod[MUL_A_W-1:0];
                            r_mul_b     <= dt;
                            r_state     <= S_OUT_B;
                        end else begin
                            r_sum   <= (first ? '0 : r_sum) + mul_prod;
                            r_state <= S_OUT_Q;
                        end
                    end
                end

                S_OUT_B: begin
                    if (mul_done) begin
                        r_sum   <= (first ? '0 : r_sum) + mul_prod;
                        r_state <= S_OUT_Q;
                    end
                end

                S_OUT_Q: begin
                    // first entry and a zero axis point take the interval velocity
                    if (first || (r_tz == '0)) begin
                        r_v2    <= r_v1;
                        r_state <= S_WR;
                    end else begin
                        r_div_start <= 1'b1;
                        r_div_num   <= r_sum;
                        r_div_den   <= r_tz;
                        r_state     <= S_OUT_D;
                    end
                end

                S_OUT_D: begin
                    if (div_done) begin
                        if (ovk_e == VK_RMS) begin
                            r_sqrt_start <= 1'b1;
                            r_sqrt_rad   <= div_quo;
                            r_state      <= S_OUT_S;
                        end else begin
                            r_v2    <= (div_quo > PROD_W'(VEL_MAX)) ? VEL_MAX
                                                                    : div_quo[VEL_W-1:0];
                            r_state <= S_WR;
                        end
                    end
                end

                S_OUT_S: begin
                    if (sqrt_done) begin
                        r_v2    <= (sqrt_root > ROOT_W'(VEL_MAX)) ? VEL_MAX
                                                                  : sqrt_root[VEL_W-1:0];
                        r_state <= S_WR;
                    end
                end

                S_WR: begin
                    r_sat_acc <= sat_acc_new;
                    r_ap      <= r_a;
                    r_hip     <= r_hi;
                    r_v1p     <= r_v1;
                    r_tzp     <= r_tz;
                    if (r_idx == last_idx) begin
                        r_ready <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_CRD;
                    end
                end

                // ---- query: end checks, binary search, interpolation ----
                Q_A0: r_state <= Q_A1;

                Q_A1: begin
                    if (r_x <= r_tz_rd) begin
                        r_valid   <= 1'b1;
                        r_vel_out <= r_v2_rd;
                        r_status  <= r_sat_rd ? ST_SAT : ST_OK;
                        r_state   <= S_IDLE;
                    end else begin
                        r_state <= Q_AN;
                    end
                end

                Q_AN: begin
                    if (r_x >= r_tz_rd) begin
                        r_valid   <= 1'b1;
                        r_vel_out <= r_v2_rd;
                        r_status  <= r_sat_rd ? ST_SAT : ST_OK;
                        r_state   <= S_IDLE;
                    end else begin
                        r_lo    <= '0;
                        r_hi_i  <= last_idx;
                        r_state <= Q_BS;
                    end
                end

                // invariant: t[lo] <= x < t[hi]
                Q_BS: r_state <= (span > (IW+1)'(1)) ? Q_BM : Q_RL;

                Q_BM: begin
                    if (r_tz_rd <= r_x) begin
                        r_lo <= mid;
                    end else begin
                        r_hi_i <= mid;
                    end
                    r_state <= Q_BS;
                end

                Q_RL: begin
                    r_t0    <= r_tz_rd;
                    r_w0    <= r_v2_rd;
                    r_state <= Q_RH;
                end

                Q_RH: begin
                    r_t1        <= r_tz_rd;
                    r_w1        <= r_v2_rd;
                    r_sat1      <= r_sat_rd;
                    r_mul_start <= 1'b1;
                    r_mul_a     <= MUL_A_W'(r_w0);
                    r_mul_b     <= r_tz_rd - r_x;
                    r_state     <= Q_M1;
                end

                Q_M1: begin
                    if (mul_done) begin
                        r_sum       <= mul_prod;
                        r_mul_start <= 1'b1;
                        r_mul_a     <= MUL_A_W'(r_w1);
                        r_mul_b     <= r_x - r_t0;
                        r_state     <= Q_M2;
                    end
                end

                Q_M2: begin
                    if (mul_done) begin
                        r_div_start <= 1'b1;
                        r_div_num   <= r_sum + mul_prod;
                        r_div_den   <= r_t1 - r_t0;
                        r_state     <= Q_DV;
                    end
                end

                Q_DV: begin
                    if (div_done) begin
                        r_valid   <= 1'b1;
                        r_vel_out <= (div_quo > PROD_W'(VEL_MAX)) ? VEL_MAX
                                                                  : div_quo[VEL_W-1:0];
                        r_status  <= r_sat1 ? ST_SAT : ST_OK;
                        r_state   <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    svc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_start),
        .i_a     (r_mul_a),
        .i_b     (r_mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    svc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    svc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sqrt_start),
        .i_rad   (r_sqrt_rad),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_velocity_out = r_vel_out;
    assign o_status       = r_status;

endmodule
